### rtl/core/weo_pkg.sv
`timescale 1ns / 1ps
package weo_pkg;

   localparam int COUNT_LIMIT   = 30000;
   localparam int CORDIC_STEPS  = 24;
   localparam int POS_FRAC_BITS = 32;

   localparam int MUL_A_W   = 54;
   localparam int MUL_B_W   = 34;
   localparam int MUL_CH    = MUL_B_W / 2;
   localparam int MUL_RES_W = 64;
   localparam int MUL_SH_W  = 6;

   localparam int ANG_W = 34;
   localparam int CORDIC_GAIN = 652032874;
   localparam int RAD_TO_BAM  = 683565276;

   localparam logic [23:0] DPC_RESET = 24'd514000;
   localparam logic [23:0] ITW_RESET = 24'd504123;
   localparam logic [23:0] IP_RESET  = 24'd327680;

   localparam logic [2:0] CSR_LEFT_INVERT  = 3'd0;
   localparam logic [2:0] CSR_RIGHT_INVERT = 3'd1;
   localparam logic [2:0] CSR_DIST_PER_CNT = 3'd2;
   localparam logic [2:0] CSR_INV_TRACK    = 3'd3;
   localparam logic [2:0] CSR_INV_PERIOD   = 3'd4;

   localparam logic [29:0] ATAN_BAM [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

   typedef struct packed {
      logic                        start;
      logic signed [MUL_A_W-1:0]   a;
      logic signed [MUL_B_W-1:0]   b;
      logic [MUL_SH_W-1:0]         sh;
   } mul_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [MUL_RES_W-1:0] res;
   } mul_rsp_type;

endpackage

### rtl/core/weo_mul.sv
`timescale 1ns / 1ps
module weo_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  weo_pkg::mul_req_type req,
   output weo_pkg::mul_rsp_type rsp
);
   localparam int AW = weo_pkg::MUL_A_W;
   localparam int BW = weo_pkg::MUL_B_W;
   localparam int CH = weo_pkg::MUL_CH;
   localparam int PW = AW + CH;
   localparam int ACW = AW + BW;
   localparam int RW = weo_pkg::MUL_RES_W;

   localparam logic [2:0] MS_IDLE = 3'd0;
   localparam logic [2:0] MS_LO   = 3'd1;
   localparam logic [2:0] MS_HI   = 3'd2;
   localparam logic [2:0] MS_ACC  = 3'd3;
   localparam logic [2:0] MS_OUT  = 3'd4;

   logic [2:0] step_ff, step_in;
   logic done_ff, done_in;
   logic [AW-1:0] a_mag_ff, a_mag_in;
   logic [BW-1:0] b_mag_ff, b_mag_in;
   logic neg_ff, neg_in;
   logic [weo_pkg::MUL_SH_W-1:0] sh_ff, sh_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [ACW-1:0] acc_ff, acc_in;
   logic signed [RW-1:0] res_ff, res_in;
   logic [ACW-1:0] half;
   logic [RW-1:0] mag;

   always_comb begin
      half = (sh_ff == '0) ? '0 : (ACW'(1) << (sh_ff - 1'b1));
      mag = RW'(acc_ff >> sh_ff);
      step_in = step_ff;
      done_in = 1'b0;
      a_mag_in = a_mag_ff;
      b_mag_in = b_mag_ff;
      neg_in = neg_ff;
      sh_in = sh_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      unique case (step_ff)
         MS_IDLE: begin
            if (req.start) begin
               a_mag_in = req.a[AW-1] ? AW'(-req.a) : AW'(req.a);
               b_mag_in = req.b[BW-1] ? BW'(-req.b) : BW'(req.b);
               neg_in = req.a[AW-1] ^ req.b[BW-1];
               sh_in = req.sh;
               step_in = MS_LO;
            end
         end
         MS_LO: begin
            prod_in = PW'(a_mag_ff) * PW'(b_mag_ff[CH-1:0]);
            step_in = MS_HI;
         end
         MS_HI: begin
            acc_in = ACW'(prod_ff) + half;
            prod_in = PW'(a_mag_ff) * PW'(b_mag_ff[BW-1:CH]);
            step_in = MS_ACC;
         end
         MS_ACC: begin
            acc_in = acc_ff + (ACW'(prod_ff) << CH);
            step_in = MS_OUT;
         end
         MS_OUT: begin
            res_in = neg_ff ? -$signed(mag) : $signed(mag);
            done_in = 1'b1;
            step_in = MS_IDLE;
         end
         default: step_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MS_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      neg_ff <= neg_in;
      sh_ff <= sh_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res = res_ff;
endmodule

### rtl/core/weo_cordic.sv
`timescale 1ns / 1ps
module weo_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [31:0]                       angle,
   output logic                              done,
   output logic signed [weo_pkg::ANG_W-1:0]  cos_val,
   output logic signed [weo_pkg::ANG_W-1:0]  sin_val
);
   localparam int W = weo_pkg::ANG_W;
   localparam int IW = 5;

   logic busy_ff, busy_in, done_ff, done_in;
   logic [IW-1:0] i_ff, i_in;
   logic [1:0] q_ff, q_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0] q_new;
   logic [31:0] r_new;
   logic signed [W-1:0] xs, ys, at;

   always_comb begin
      q_new = 2'((angle + 32'h2000_0000) >> 30);
      r_new = angle - {q_new, 30'd0};
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = W'(weo_pkg::ATAN_BAM[i_ff]);
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in = i_ff;
      q_in = q_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         busy_in = 1'b1;
         i_in = '0;
         q_in = q_new;
         x_in = W'(weo_pkg::CORDIC_GAIN);
         y_in = '0;
         z_in = W'($signed(r_new));
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(weo_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      i_ff <= i_in;
      q_ff <= q_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // fold the reduced angle back into its quadrant
   always_comb begin
      unique case (q_ff)
         2'd0: begin cos_val = x_ff;  sin_val = y_ff;  end
         2'd1: begin cos_val = -y_ff; sin_val = x_ff;  end
         2'd2: begin cos_val = -x_ff; sin_val = -y_ff; end
         default: begin cos_val = y_ff; sin_val = -x_ff; end
      endcase
   end

   assign done = done_ff;
endmodule

### rtl/core/wheel_encoder_odometry.sv
`timescale 1ns / 1ps
// Wheel encoder odometry.
// req_* carries one sample: command, left and right counter readings and the
// counters-cleared flag. rsp_* returns one result beat per sample: deltas,
// totals, rates, position, heading, speeds and the record number.
// csr_* writes the five setup registers by index, one per write-enable cycle;
// write them only while the block is idle.
// Work per sample: 10 multiplies on the shared multiplier, which forms each
// 54x34 product from two 54x17 partial products, with the CORDIC sine and
// cosine run after the sixth, then the result load. req_ready is low
// meanwhile, so no new sample is taken until the result is loaded.
// A finished result waits in the output register; req_ready comes back as
// soon as the result is loaded, so the next sample runs while the receiver
// stalls. A second result waits for the first to be taken.
// Reset (synchronous) clears all odometry state, loads the setup register
// defaults and drops rsp_valid.
module wheel_encoder_odometry (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [15:0] req_left_count,
   input  logic signed [15:0] req_right_count,
   input  logic               req_counters_cleared,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_left_delta,
   output logic signed [16:0] rsp_right_delta,
   output logic signed [31:0] rsp_left_sum,
   output logic signed [31:0] rsp_right_sum,
   output logic signed [24:0] rsp_left_rate,
   output logic signed [24:0] rsp_right_rate,
   output logic signed [31:0] rsp_x_pos,
   output logic signed [31:0] rsp_y_pos,
   output logic signed [31:0] rsp_heading,
   output logic signed [31:0] rsp_linear_speed,
   output logic signed [31:0] rsp_angular_speed,
   output logic [31:0]        rsp_record_number,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wr_data
);
   localparam int AW = weo_pkg::MUL_A_W;
   localparam int BW = weo_pkg::MUL_B_W;
   localparam int RW = weo_pkg::MUL_RES_W;
   localparam int SW = weo_pkg::MUL_SH_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_GO   = 3'd1;
   localparam logic [2:0] ST_MUL_WAIT = 3'd2;
   localparam logic [2:0] ST_COR_GO   = 3'd3;
   localparam logic [2:0] ST_COR_WAIT = 3'd4;
   localparam logic [2:0] ST_FIN      = 3'd5;

   localparam logic [3:0] OP_LRATE = 4'd0;
   localparam logic [3:0] OP_RRATE = 4'd1;
   localparam logic [3:0] OP_SUM   = 4'd2;
   localparam logic [3:0] OP_DIFF  = 4'd3;
   localparam logic [3:0] OP_DTH   = 4'd4;
   localparam logic [3:0] OP_DANG  = 4'd5;
   localparam logic [3:0] OP_DX    = 4'd6;
   localparam logic [3:0] OP_DY    = 4'd7;
   localparam logic [3:0] OP_V     = 4'd8;
   localparam logic [3:0] OP_W     = 4'd9;

   // setup registers
   logic linv_ff, rinv_ff;
   logic [23:0] dpc_ff, itw_ff, ip_ff;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;

   logic signed [15:0] llast_ff, rlast_ff;
   logic signed [31:0] ltot_ff, rtot_ff;
   logic signed [47:0] x_ff, y_ff;
   logic [31:0] h_ff, seq_ff;

   logic signed [16:0] dl_ff, dr_ff;
   logic signed [RW-1:0] lrate_ff, rrate_ff, sum_ff, diff_ff, dth_ff, dang_ff;
   logic signed [RW-1:0] dx_ff, dy_ff, v_ff, w_ff;

   logic rsp_valid_ff;
   logic signed [16:0] o_dl_ff, o_dr_ff;
   logic signed [31:0] o_lsum_ff, o_rsum_ff, o_x_ff, o_y_ff, o_h_ff, o_v_ff, o_w_ff;
   logic signed [24:0] o_lr_ff, o_rr_ff;
   logic [31:0] o_rec_ff;

   weo_pkg::mul_req_type mreq;
   weo_pkg::mul_rsp_type mrsp;
   logic cor_start, cor_done;
   logic signed [weo_pkg::ANG_W-1:0] cos_v, sin_v;

   logic accept, load_out;
   logic signed [15:0] lc, rc;
   logic signed [16:0] dl_raw, dr_raw, dl_new, dr_new;
   logic signed [RW-1:0] dang_half;
   logic [31:0] mid;
   logic signed [47:0] x_new, y_new;
   logic [31:0] h_new;

   function automatic logic signed [15:0] clamp_count(input logic signed [15:0] v);
      if (v > 16'(weo_pkg::COUNT_LIMIT)) return 16'(weo_pkg::COUNT_LIMIT);
      else if (v < -16'(weo_pkg::COUNT_LIMIT)) return -16'(weo_pkg::COUNT_LIMIT);
      else return v;
   endfunction

   function automatic logic signed [24:0] sat_rate(input logic signed [63:0] v);
      if (v > 64'sd16777215) return 25'sd16777215;
      else if (v < -64'sd16777215) return -25'sd16777215;
      else return 25'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      else if (v < -64'sd2147483648) return 32'sh8000_0000;
      else return 32'(v);
   endfunction

   function automatic logic signed [31:0] pos_out(input logic signed [47:0] v);
      logic signed [79:0] e;
      e = 80'(v);
      e = e >>> (weo_pkg::POS_FRAC_BITS - 16);
      return e[31:0];
   endfunction

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign load_out = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // sample front end: clamp, delta, invert
   always_comb begin
      lc = clamp_count(req_left_count);
      rc = clamp_count(req_right_count);
      dl_raw = 17'(lc) - (req_cmd ? 17'sd0 : 17'(llast_ff));
      dr_raw = 17'(rc) - (req_cmd ? 17'sd0 : 17'(rlast_ff));
      dl_new = linv_ff ? -dl_raw : dl_raw;
      dr_new = rinv_ff ? -dr_raw : dr_raw;
   end

   always_comb begin
      dang_half = (dang_ff + RW'(dang_ff < 0)) >>> 1;
      mid = h_ff + dang_half[31:0];
      x_new = x_ff + dx_ff[47:0];
      y_new = y_ff + dy_ff[47:0];
      h_new = h_ff + dang_ff[31:0];
   end

   // operand select for the shared multiplier
   always_comb begin
      mreq.start = (state_ff == ST_MUL_GO);
      mreq.a = '0;
      mreq.b = '0;
      mreq.sh = '0;
      unique case (op_ff)
         OP_LRATE: begin mreq.a = AW'(dl_ff); mreq.b = BW'(ip_ff); mreq.sh = SW'(16); end
         OP_RRATE: begin mreq.a = AW'(dr_ff); mreq.b = BW'(ip_ff); mreq.sh = SW'(16); end
         OP_SUM: begin
            mreq.a = AW'(dl_ff) + AW'(dr_ff); mreq.b = BW'(dpc_ff); mreq.sh = '0;
         end
         OP_DIFF: begin
            mreq.a = AW'(dr_ff) - AW'(dl_ff); mreq.b = BW'(dpc_ff); mreq.sh = '0;
         end
         OP_DTH: begin mreq.a = AW'(diff_ff); mreq.b = BW'(itw_ff); mreq.sh = SW'(16); end
         OP_DANG: begin
            mreq.a = AW'(dth_ff); mreq.b = BW'(weo_pkg::RAD_TO_BAM); mreq.sh = SW'(32);
         end
         OP_DX: begin
            mreq.a = AW'(sum_ff); mreq.b = cos_v;
            mreq.sh = SW'(63 - weo_pkg::POS_FRAC_BITS);
         end
         OP_DY: begin
            mreq.a = AW'(sum_ff); mreq.b = sin_v;
            mreq.sh = SW'(63 - weo_pkg::POS_FRAC_BITS);
         end
         OP_V: begin mreq.a = AW'(sum_ff); mreq.b = BW'(ip_ff); mreq.sh = SW'(33); end
         OP_W: begin mreq.a = AW'(dth_ff); mreq.b = BW'(ip_ff); mreq.sh = SW'(32); end
         default: begin mreq.a = '0; mreq.b = '0; mreq.sh = '0; end
      endcase
   end

   assign cor_start = (state_ff == ST_COR_GO);

   weo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   weo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (mid),
      .done    (cor_done),
      .cos_val (cos_v),
      .sin_val (sin_v)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL_GO;
               op_in = OP_LRATE;
            end
         end
         ST_MUL_GO: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mrsp.done) begin
               if (op_ff == OP_DANG) begin
                  state_in = ST_COR_GO;
                  op_in = OP_DX;
               end else if (op_ff == OP_W) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_MUL_GO;
                  op_in = op_ff + 1'b1;
               end
            end
         end
         ST_COR_GO: state_in = ST_COR_WAIT;
         ST_COR_WAIT: if (cor_done) state_in = ST_MUL_GO;
         ST_FIN: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_LRATE;
         rsp_valid_ff <= 1'b0;
         linv_ff <= 1'b0;
         rinv_ff <= 1'b0;
         dpc_ff <= weo_pkg::DPC_RESET;
         itw_ff <= weo_pkg::ITW_RESET;
         ip_ff <= weo_pkg::IP_RESET;
         llast_ff <= '0;
         rlast_ff <= '0;
         ltot_ff <= '0;
         rtot_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         h_ff <= '0;
         seq_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               weo_pkg::CSR_LEFT_INVERT:  linv_ff <= csr_wr_data[0];
               weo_pkg::CSR_RIGHT_INVERT: rinv_ff <= csr_wr_data[0];
               weo_pkg::CSR_DIST_PER_CNT: dpc_ff <= csr_wr_data;
               weo_pkg::CSR_INV_TRACK:    itw_ff <= csr_wr_data;
               weo_pkg::CSR_INV_PERIOD:   ip_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (accept) begin
            ltot_ff <= (req_cmd ? 32'sd0 : ltot_ff) + 32'(dl_new);
            rtot_ff <= (req_cmd ? 32'sd0 : rtot_ff) + 32'(dr_new);
            llast_ff <= req_counters_cleared ? 16'sd0 : lc;
            rlast_ff <= req_counters_cleared ? 16'sd0 : rc;
            seq_ff <= (req_cmd ? 32'd0 : seq_ff) + 32'd1;
            if (req_cmd) begin
               x_ff <= '0;
               y_ff <= '0;
               h_ff <= '0;
            end
         end
         if (load_out) begin
            x_ff <= x_new;
            y_ff <= y_new;
            h_ff <= h_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         dl_ff <= dl_new;
         dr_ff <= dr_new;
      end
      if (state_ff == ST_MUL_WAIT && mrsp.done) begin
         unique case (op_ff)
            OP_LRATE: lrate_ff <= mrsp.res;
            OP_RRATE: rrate_ff <= mrsp.res;
            OP_SUM:   sum_ff <= mrsp.res;
            OP_DIFF:  diff_ff <= mrsp.res;
            OP_DTH:   dth_ff <= mrsp.res;
            OP_DANG:  dang_ff <= mrsp.res;
            OP_DX:    dx_ff <= mrsp.res;
            OP_DY:    dy_ff <= mrsp.res;
            OP_V:     v_ff <= mrsp.res;
            OP_W:     w_ff <= mrsp.res;
            default: ;
         endcase
      end
      if (load_out) begin
         o_dl_ff <= dl_ff;
         o_dr_ff <= dr_ff;
         o_lsum_ff <= ltot_ff;
         o_rsum_ff <= rtot_ff;
         o_lr_ff <= sat_rate(lrate_ff);
         o_rr_ff <= sat_rate(rrate_ff);
         o_x_ff <= pos_out(x_new);
         o_y_ff <= pos_out(y_new);
         o_h_ff <= h_new;
         o_v_ff <= sat32(v_ff);
         o_w_ff <= sat32(w_ff);
         o_rec_ff <= seq_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_delta = o_dl_ff;
   assign rsp_right_delta = o_dr_ff;
   assign rsp_left_sum = o_lsum_ff;
   assign rsp_right_sum = o_rsum_ff;
   assign rsp_left_rate = o_lr_ff;
   assign rsp_right_rate = o_rr_ff;
   assign rsp_x_pos = o_x_ff;
   assign rsp_y_pos = o_y_ff;
   assign rsp_heading = o_h_ff;
   assign rsp_linear_speed = o_v_ff;
   assign rsp_angular_speed = o_w_ff;
   assign rsp_record_number = o_rec_ff;
endmodule

### rtl/core/weo_checker.sv
`timescale 1ns / 1ps
module weo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_record_number
);
   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the block works on one sample at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after accept");

   // a new result does not appear in the cycle after an accept
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared right after accept");

   // stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_record_number)))
      else $error("stalled result changed");
endmodule

bind wheel_encoder_odometry weo_checker u_weo_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_record_number (rsp_record_number)
);

### tb/sv/wheel_encoder_odometry_checker.sv
`timescale 1ns / 1ps
module wheel_encoder_odometry_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [15:0] req_left_count,
   input  logic signed [15:0] req_right_count,
   input  logic               req_counters_cleared,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [16:0] rsp_left_delta,
   input  logic signed [16:0] rsp_right_delta,
   input  logic signed [31:0] rsp_left_sum,
   input  logic signed [31:0] rsp_right_sum,
   input  logic signed [24:0] rsp_left_rate,
   input  logic signed [24:0] rsp_right_rate,
   input  logic signed [31:0] rsp_x_pos,
   input  logic signed [31:0] rsp_y_pos,
   input  logic signed [31:0] rsp_heading,
   input  logic signed [31:0] rsp_linear_speed,
   input  logic signed [31:0] rsp_angular_speed,
   input  logic [31:0]        rsp_record_number,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wr_data,
   output int                 errors,
   output int                 outstanding
);

   typedef struct {
      logic [16:0] left_delta;
      logic [16:0] right_delta;
      logic [31:0] left_sum;
      logic [31:0] right_sum;
      logic [24:0] left_rate;
      logic [24:0] right_rate;
      logic [31:0] x_pos;
      logic [31:0] y_pos;
      logic [31:0] heading;
      logic [31:0] linear_speed;
      logic [31:0] angular_speed;
      logic [31:0] record_number;
   } odo_result_type;

   odo_result_type odo_expected[$];

   logic        left_inv, right_inv;
   logic [23:0] dist_per_cnt, inv_track, inv_period;
   int          left_prev, right_prev;
   logic [31:0] left_tot, right_tot, head_ang, seq_num;
   logic [47:0] x_acc, y_acc;

   initial begin
      errors = 0;
      outstanding = 0;
   end

   function automatic longint round_mul(longint a, longint b, int s);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic         neg;
      longint       r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p + (128'd1 << (s - 1));
      p = (p >> s) & 128'h3FFF_FFFF_FFFF_FFFF;
      r = p[63:0];
      return neg ? -r : r;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int clip_reading(logic signed [15:0] v);
      return int'(clamp(longint'(v), -longint'(weo_pkg::COUNT_LIMIT),
                        longint'(weo_pkg::COUNT_LIMIT)));
   endfunction

   function automatic logic [31:0] pos_word(logic [47:0] acc);
      longint sv;
      sv = $signed(acc);
      sv = sv >>> (weo_pkg::POS_FRAC_BITS - 16);
      return sv[31:0];
   endfunction

   task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic [1:0]  q;
      logic [31:0] r, qa;
      longint      x, y, t, z;
      qa = ang + 32'h2000_0000;
      q = qa[31:30];
      r = ang - {q, 30'd0};
      z = $signed(r);
      x = longint'(weo_pkg::CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < weo_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(weo_pkg::ATAN_BAM[i]);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(weo_pkg::ATAN_BAM[i]);
         end
         x = t;
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic clear_odometry();
      left_prev = 0;
      right_prev = 0;
      left_tot = 0;
      right_tot = 0;
      x_acc = 0;
      y_acc = 0;
      head_ang = 0;
      seq_num = 0;
   endtask

   task automatic predict_odometry(input logic cmd, input logic signed [15:0] lraw,
                                   input logic signed [15:0] rraw, input logic cleared);
      int             lc, rc, dl, dr;
      longint         sum, diff, dth, dang, c, s, dx, dy, lr, rr, v, w;
      logic [31:0]    mid;
      odo_result_type e;
      if (cmd) clear_odometry();
      lc = clip_reading(lraw);
      rc = clip_reading(rraw);
      dl = lc - left_prev;
      dr = rc - right_prev;
      if (left_inv) dl = -dl;
      if (right_inv) dr = -dr;
      left_tot = left_tot + dl;
      right_tot = right_tot + dr;
      left_prev = cleared ? 0 : lc;
      right_prev = cleared ? 0 : rc;
      lr = clamp(round_mul(dl, inv_period, 16), -16777215, 16777215);
      rr = clamp(round_mul(dr, inv_period, 16), -16777215, 16777215);
      sum = longint'(dr) * dist_per_cnt + longint'(dl) * dist_per_cnt;
      diff = longint'(dr) * dist_per_cnt - longint'(dl) * dist_per_cnt;
      dth = round_mul(diff, inv_track, 16);
      dang = round_mul(dth, longint'(weo_pkg::RAD_TO_BAM), 32);
      mid = head_ang + 32'(dang / 2);
      sin_cos(mid, c, s);
      dx = round_mul(sum, c, 63 - weo_pkg::POS_FRAC_BITS);
      dy = round_mul(sum, s, 63 - weo_pkg::POS_FRAC_BITS);
      x_acc = x_acc + dx[47:0];
      y_acc = y_acc + dy[47:0];
      head_ang = head_ang + dang[31:0];
      v = clamp(round_mul(sum, inv_period, 33), -64'sd2147483648, 64'sd2147483647);
      w = clamp(round_mul(dth, inv_period, 32), -64'sd2147483648, 64'sd2147483647);
      seq_num = seq_num + 1;
      e.left_delta = dl[16:0];
      e.right_delta = dr[16:0];
      e.left_sum = left_tot;
      e.right_sum = right_tot;
      e.left_rate = lr[24:0];
      e.right_rate = rr[24:0];
      e.x_pos = pos_word(x_acc);
      e.y_pos = pos_word(y_acc);
      e.heading = head_ang;
      e.linear_speed = v[31:0];
      e.angular_speed = w[31:0];
      e.record_number = seq_num;
      odo_expected.push_back(e);
   endtask

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
      errors++;
   endtask

   task automatic compare_result();
      odo_result_type e;
      if (odo_expected.size() == 0) begin
         $display("mismatch at %0t: result beat with nothing pending", $realtime);
         errors++;
         return;
      end
      e = odo_expected.pop_front();
      if (rsp_left_delta !== e.left_delta) report("left_delta", rsp_left_delta, e.left_delta);
      if (rsp_right_delta !== e.right_delta)
         report("right_delta", rsp_right_delta, e.right_delta);
      if (rsp_left_sum !== e.left_sum) report("left_sum", rsp_left_sum, e.left_sum);
      if (rsp_right_sum !== e.right_sum) report("right_sum", rsp_right_sum, e.right_sum);
      if (rsp_left_rate !== e.left_rate) report("left_rate", rsp_left_rate, e.left_rate);
      if (rsp_right_rate !== e.right_rate) report("right_rate", rsp_right_rate, e.right_rate);
      if (rsp_x_pos !== e.x_pos) report("x_pos", rsp_x_pos, e.x_pos);
      if (rsp_y_pos !== e.y_pos) report("y_pos", rsp_y_pos, e.y_pos);
      if (rsp_heading !== e.heading) report("heading", rsp_heading, e.heading);
      if (rsp_linear_speed !== e.linear_speed)
         report("linear_speed", rsp_linear_speed, e.linear_speed);
      if (rsp_angular_speed !== e.angular_speed)
         report("angular_speed", rsp_angular_speed, e.angular_speed);
      if (rsp_record_number !== e.record_number)
         report("record_number", rsp_record_number, e.record_number);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_odometry();
         left_inv = 1'b0;
         right_inv = 1'b0;
         dist_per_cnt = weo_pkg::DPC_RESET;
         inv_track = weo_pkg::ITW_RESET;
         inv_period = weo_pkg::IP_RESET;
         odo_expected.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               weo_pkg::CSR_LEFT_INVERT:  left_inv = csr_wr_data[0];
               weo_pkg::CSR_RIGHT_INVERT: right_inv = csr_wr_data[0];
               weo_pkg::CSR_DIST_PER_CNT: dist_per_cnt = csr_wr_data;
               weo_pkg::CSR_INV_TRACK:    inv_track = csr_wr_data;
               weo_pkg::CSR_INV_PERIOD:   inv_period = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready)
            predict_odometry(req_cmd, req_left_count, req_right_count, req_counters_cleared);
      end
      outstanding = odo_expected.size();
   end

endmodule

### tb/sv/wheel_encoder_odometry_test.sv
`timescale 1ns / 1ps
module wheel_encoder_odometry_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = 1'b0;
   logic signed [15:0] req_left_count = '0;
   logic signed [15:0] req_right_count = '0;
   logic               req_counters_cleared = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_left_delta, rsp_right_delta;
   logic signed [31:0] rsp_left_sum, rsp_right_sum;
   logic signed [24:0] rsp_left_rate, rsp_right_rate;
   logic signed [31:0] rsp_x_pos, rsp_y_pos, rsp_heading;
   logic signed [31:0] rsp_linear_speed, rsp_angular_speed;
   logic [31:0]        rsp_record_number;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wr_data = '0;
   int                 errors, outstanding;
   bit                 busy_sender = 1'b1;
   bit                 busy_receiver = 1'b1;
   int                 left_walk = 0, right_walk = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   wheel_encoder_odometry dut (.*);

   wheel_encoder_odometry_checker checker_i (.*);

   function automatic int pick_gap(bit busy);
      int r;
      r = $urandom_range(0, 99);
      if (!busy || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 6);
      return $urandom_range(20, 120);
   endfunction

   task automatic send_sample(input logic cmd, input logic signed [15:0] lc,
                              input logic signed [15:0] rc, input logic cleared);
      repeat (pick_gap(busy_sender)) @(negedge clock);
      req_valid = 1'b1;
      req_cmd = cmd;
      req_left_count = lc;
      req_right_count = rc;
      req_counters_cleared = cleared;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] data);
      while (outstanding != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_config(input logic li, input logic ri, input logic [23:0] dpc,
                             input logic [23:0] itw, input logic [23:0] ip);
      write_csr(weo_pkg::CSR_LEFT_INVERT, {23'd0, li});
      write_csr(weo_pkg::CSR_RIGHT_INVERT, {23'd0, ri});
      write_csr(weo_pkg::CSR_DIST_PER_CNT, dpc);
      write_csr(weo_pkg::CSR_INV_TRACK, itw);
      write_csr(weo_pkg::CSR_INV_PERIOD, ip);
   endtask

   function automatic int next_reading(int cur);
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         n = cur + $urandom_range(0, 6000) - 3000;
         if (n > weo_pkg::COUNT_LIMIT) n = weo_pkg::COUNT_LIMIT;
         if (n < -weo_pkg::COUNT_LIMIT) n = -weo_pkg::COUNT_LIMIT;
         return n;
      end
      if (r < 92) return $signed(16'($urandom()));
      case ($urandom_range(0, 3))
         0: return weo_pkg::COUNT_LIMIT;
         1: return -weo_pkg::COUNT_LIMIT;
         2: return 32767;
         default: return -32768;
      endcase
   endfunction

   task automatic random_samples(input int n);
      logic cmd, cleared;
      for (int i = 0; i < n; i++) begin
         cmd = ($urandom_range(0, 99) < 3);
         cleared = ($urandom_range(0, 99) < 6);
         left_walk = next_reading(left_walk);
         right_walk = next_reading(right_walk);
         send_sample(cmd, 16'(left_walk), 16'(right_walk), cleared);
         if (cmd || cleared) begin
            left_walk = 0;
            right_walk = 0;
         end
      end
   endtask

   // receiver: random stalls, plus one long hold-off that backs up the block
   initial begin
      int taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == 150) begin
            rsp_ready = 1'b0;
            repeat (700) @(negedge clock);
            taken++;
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         if (rsp_valid) taken++;
         @(negedge clock);
         if (pick_gap(busy_receiver) > 0) begin
            rsp_ready = 1'b0;
            repeat (pick_gap(busy_receiver)) @(negedge clock);
         end
      end
   end

   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reading extremes, big swings, reset command, cleared counters, extreme and zero setup values
      send_sample(1'b0, 16'sd0, 16'sd0, 1'b0);
      send_sample(1'b0, -16'sd30000, 16'sd30000, 1'b0);
      send_sample(1'b0, 16'sd30000, -16'sd30000, 1'b0);
      send_sample(1'b0, 16'sd32767, -16'sd32768, 1'b0);
      send_sample(1'b0, -16'sd32768, 16'sd32767, 1'b0);
      send_sample(1'b0, 16'sd30001, -16'sd30001, 1'b1);
      send_sample(1'b0, 16'sd1, -16'sd1, 1'b0);
      send_sample(1'b1, 16'sd500, 16'sd700, 1'b0);
      send_sample(1'b1, -16'sd1, 16'sh7FFF, 1'b1);
      send_sample(1'b0, 16'sd12345, 16'sd12345, 1'b0);
      send_sample(1'b0, 16'sd12000, 16'sd12700, 1'b0);
      set_config(1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_sample(1'b0, -16'sd30000, 16'sd30000, 1'b0);
      send_sample(1'b0, 16'sd30000, -16'sd30000, 1'b0);
      send_sample(1'b0, 16'sd30000, 16'sd30000, 1'b0);
      set_config(1'b0, 1'b1, 24'd0, 24'd0, 24'd0);
      send_sample(1'b0, 16'sd2000, -16'sd3000, 1'b0);
      send_sample(1'b0, -16'sd30000, 16'sd30000, 1'b1);

      set_config(1'b0, 1'b0, weo_pkg::DPC_RESET, weo_pkg::ITW_RESET, weo_pkg::IP_RESET);
      left_walk = 0;
      right_walk = 0;
      busy_sender = 1'b1;
      random_samples(250);
      busy_sender = 1'b0;
      busy_receiver = 1'b0;
      set_config(1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      random_samples(150);
      busy_sender = 1'b1;
      busy_receiver = 1'b1;
      set_config(1'b0, 1'b1, 24'd0, 24'd1, 24'd0);
      random_samples(100);
      for (int ph = 0; ph < 5; ph++) begin
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)));
         busy_receiver = (ph != 2);
         random_samples(100);
      end

      while (outstanding != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
